@@ design/omv_pkg.sv @@
// Shared widths and handshake structs for the online mean and variance block.
package omv_pkg;

    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 32;
    localparam int MEAN_W   = 32;
    localparam int VAR_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int DEN_W    = 32;

    typedef struct packed {
        logic start;
        logic short_op;
    } omv_div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } omv_unit_stat_t;

endpackage

@@ design/omv_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, 32 or 64 quotient bits.
module omv_div
    import omv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  omv_div_ctrl_t        ctrl,
    input  logic [VAR_W-1:0]     dividend,
    input  logic [DEN_W-1:0]     divisor,
    output omv_unit_stat_t       stat,
    output logic [VAR_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(VAR_W);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [VAR_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Bring down the next dividend bit and try a subtraction.
    assign trial = {rem_reg, quo_reg[VAR_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            rem_reg <= '0;
            den_reg <= divisor;
            if (ctrl.short_op) begin
                quo_reg <= {dividend[DEN_W-1:0], DEN_W'(0)};
                cnt_reg <= CNT_W'(DEN_W - 1);
            end else begin
                quo_reg <= dividend;
                cnt_reg <= CNT_W'(VAR_W - 1);
            end
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[VAR_W-2:0], fits};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

@@ design/omv_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
module omv_sqrt
    import omv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VAR_W-1:0]   radicand,
    output omv_unit_stat_t     stat,
    output logic [ROOT_W-1:0]  root
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 2;

    logic [VAR_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W+1:0]  cand;
    logic [REM_W+1:0]  sub;
    logic [REM_W+1:0]  diff;
    logic              fits;

    // Append the next two radicand bits and test against 4*root + 1.
    assign cand = {rem_reg, rad_reg[VAR_W-1:VAR_W-2]};
    assign sub  = (REM_W + 2)'({root_reg, 2'b01});
    assign diff = cand - sub;
    assign fits = cand >= sub;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= CNT_W'(ROOT_W - 1);
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[VAR_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[REM_W-1:0] : cand[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

@@ design/online_mean_variance_top.sv @@
// Top level of the online mean and variance block: sequencer, Welford update and output register.
//
// The block takes one signed Q16.16 sample per beat and returns one result beat
// holding the saturating sample count, the running mean (Welford update, the
// mean step truncated toward zero), the sample variance M2/(n-1) in Q32.32 and
// its floor square root in Q16.16. With one sample or fewer the variance and
// standard deviation read all ones and m_variance_valid is low. Items are
// processed one at a time: s_ready is high only while the sequencer is idle.
// A later sample passes through a short-form divide of the mean step by the
// count, a shift-add multiply for the squared-deviation term, a divide of M2
// by n-1 on the shared radix-2 divider, and a square root, with setup and
// handoff states between the steps. The block takes no new sample until the
// result has gone into the output register. The first sample after reset
// skips these steps and goes straight to the output state. A finished result
// sits in the output register, so the next sample can be accepted while the
// previous result still waits for m_ready.
module online_mean_variance_top
    import omv_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [COUNT_W-1:0]       m_sample_count,
    output logic signed [MEAN_W-1:0] m_running_mean,
    output logic [VAR_W-1:0]         m_sample_variance,
    output logic [ROOT_W-1:0]        m_std_deviation,
    output logic                     m_variance_valid
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_MDIV   = 4'd2;
    localparam logic [3:0] S_D1     = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_ACC    = 4'd5;
    localparam logic [3:0] S_VSTART = 4'd6;
    localparam logic [3:0] S_VDIV   = 4'd7;
    localparam logic [3:0] S_SQRT   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    localparam int MUL_CNT_W = $clog2(MEAN_W);

    logic [3:0]               state_reg;
    logic [3:0]               state_next;

    // Welford state.
    logic [COUNT_W-1:0]       count_reg;
    logic signed [MEAN_W-1:0] mean_reg;
    logic [VAR_W-1:0]         sq_reg;

    // Working registers for the current sample.
    logic signed [MEAN_W-1:0] sample_reg;
    logic [MEAN_W-1:0]        mag0_reg;
    logic                     neg_reg;
    logic                     var_ok_reg;
    logic [MEAN_W-1:0]        prod_hi_reg;
    logic [MEAN_W-1:0]        prod_lo_reg;
    logic [MUL_CNT_W-1:0]     mul_cnt_reg;
    logic [VAR_W-1:0]         var_reg;

    // Output register.
    logic                     m_valid_reg;
    logic [COUNT_W-1:0]       out_count_reg;
    logic signed [MEAN_W-1:0] out_mean_reg;
    logic [VAR_W-1:0]         out_var_reg;
    logic [ROOT_W-1:0]        out_root_reg;
    logic                     out_ok_reg;

    logic                     s_take;
    logic                     out_load;
    logic signed [MEAN_W:0]   d0;
    logic signed [MEAN_W:0]   d1;
    logic [MEAN_W:0]          d0_neg;
    logic [MEAN_W:0]          d1_abs;
    logic [MEAN_W-1:0]        step_q;
    logic signed [MEAN_W-1:0] mean_upd;
    logic [MEAN_W:0]          mul_sum;
    logic [VAR_W:0]           acc_sum;

    omv_div_ctrl_t            div_ctrl;
    omv_unit_stat_t           div_stat;
    omv_unit_stat_t           sqrt_stat;
    logic [VAR_W-1:0]         div_dividend;
    logic [DEN_W-1:0]         div_divisor;
    logic [VAR_W-1:0]         div_quotient;
    logic                     sqrt_start;
    logic [ROOT_W-1:0]        sqrt_root;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_take   = s_valid && s_ready;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    // Deviation of the sample from the old mean, and from the new mean.
    assign d0     = {sample_reg[MEAN_W-1], sample_reg} - {mean_reg[MEAN_W-1], mean_reg};
    assign d0_neg = -d0;
    assign d1     = {sample_reg[MEAN_W-1], sample_reg} - {mean_reg[MEAN_W-1], mean_reg};
    assign d1_abs = d1[MEAN_W] ? -d1 : d1;

    assign step_q   = div_quotient[MEAN_W-1:0];
    assign mean_upd = neg_reg ? (mean_reg - $signed(step_q)) : (mean_reg + $signed(step_q));

    // One shift-add step of the multiplier: add the multiplicand when the low bit is set.
    assign mul_sum = {1'b0, prod_hi_reg} + (prod_lo_reg[0] ? {1'b0, mag0_reg} : '0);
    assign acc_sum = {1'b0, sq_reg} + {1'b0, prod_hi_reg, prod_lo_reg};

    // The divider serves both the mean step (short form) and the variance.
    always_comb begin
        div_ctrl.start    = 1'b0;
        div_ctrl.short_op = 1'b0;
        div_dividend      = sq_reg;
        div_divisor       = DEN_W'(count_reg - COUNT_W'(1));
        if (state_reg == S_PREP && count_reg != COUNT_W'(1)) begin
            div_ctrl.start    = 1'b1;
            div_ctrl.short_op = 1'b1;
            div_dividend      = VAR_W'(d0[MEAN_W] ? d0_neg[MEAN_W-1:0] : d0[MEAN_W-1:0]);
            div_divisor       = DEN_W'(count_reg);
        end else if (state_reg == S_VSTART) begin
            div_ctrl.start    = 1'b1;
        end
    end

    assign sqrt_start = (state_reg == S_VDIV) && div_stat.done;

    omv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    omv_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_quotient),
        .stat     (sqrt_stat),
        .root     (sqrt_root)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_take) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                state_next = (count_reg == COUNT_W'(1)) ? S_OUT : S_MDIV;
            end
            S_MDIV: begin
                if (div_stat.done) begin
                    state_next = S_D1;
                end
            end
            S_D1: begin
                state_next = S_MUL;
            end
            S_MUL: begin
                if (mul_cnt_reg == '0) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                state_next = S_VSTART;
            end
            S_VSTART: begin
                state_next = S_VDIV;
            end
            S_VDIV: begin
                if (div_stat.done) begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_stat.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and the Welford state, all cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            mean_reg    <= '0;
            sq_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_take && count_reg != '1) begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (state_reg == S_PREP && count_reg == COUNT_W'(1)) begin
                mean_reg <= sample_reg;
            end else if (state_reg == S_MDIV && div_stat.done) begin
                mean_reg <= mean_upd;
            end
            if (state_reg == S_ACC) begin
                sq_reg <= acc_sum[VAR_W] ? '1 : acc_sum[VAR_W-1:0];
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers for the sample in flight and the output register.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            sample_reg <= MEAN_W'(s_sample);
        end
        if (state_reg == S_PREP) begin
            var_ok_reg <= (count_reg != COUNT_W'(1));
            neg_reg    <= d0[MEAN_W];
            mag0_reg   <= d0[MEAN_W] ? d0_neg[MEAN_W-1:0] : d0[MEAN_W-1:0];
        end
        if (state_reg == S_D1) begin
            prod_hi_reg <= '0;
            prod_lo_reg <= d1_abs[MEAN_W-1:0];
            mul_cnt_reg <= MUL_CNT_W'(MEAN_W - 1);
        end else if (state_reg == S_MUL) begin
            prod_hi_reg <= mul_sum[MEAN_W:1];
            prod_lo_reg <= {mul_sum[0], prod_lo_reg[MEAN_W-1:1]};
            mul_cnt_reg <= mul_cnt_reg - MUL_CNT_W'(1);
        end
        if (sqrt_start) begin
            var_reg <= div_quotient;
        end
        if (out_load) begin
            out_count_reg <= count_reg;
            out_mean_reg  <= mean_reg;
            out_var_reg   <= var_ok_reg ? var_reg : '1;
            out_root_reg  <= var_ok_reg ? sqrt_root : '1;
            out_ok_reg    <= var_ok_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_sample_count    = out_count_reg;
    assign m_running_mean    = out_mean_reg;
    assign m_sample_variance = out_var_reg;
    assign m_std_deviation   = out_root_reg;
    assign m_variance_valid  = out_ok_reg;

`ifndef SYNTHESIS
    // The iterative units are idle whenever a new sample can be taken.
    a_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!div_stat.busy && !sqrt_stat.busy))
        else $error("divider or square root busy while the block is idle");

    // Divider results only arrive while the sequencer waits for them.
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_MDIV || state_reg == S_VDIV))
        else $error("divider finished outside a divide state");

    // The valid flag follows the reported count.
    a_valid_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_variance_valid == (m_sample_count > COUNT_W'(1))))
        else $error("variance valid flag disagrees with the sample count");

    // Without a valid variance both statistics read all ones.
    a_invalid_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_variance_valid) |->
            (m_sample_variance == '1 && m_std_deviation == '1))
        else $error("invalid variance result not saturated");
`endif

endmodule
